// ===== rtl/rlx_pkg.sv =====
`default_nettype none
package rlx_pkg;

   // scanner states
   typedef enum logic [4:0] {
      ST_START  = 5'd0,
      ST_LT     = 5'd1,
      ST_GT     = 5'd2,
      ST_IDENT  = 5'd3,
      ST_INT    = 5'd4,
      ST_DOT    = 5'd5,
      ST_FRAC   = 5'd6,
      ST_EXP    = 5'd7,
      ST_EXPSGN = 5'd8,
      ST_EXPDIG = 5'd9
   } scan_state_type;

   // token kinds
   localparam logic [2:0] KIND_RELOP = 3'd0;
   localparam logic [2:0] KIND_ID    = 3'd1;
   localparam logic [2:0] KIND_NUM   = 3'd2;
   localparam logic [2:0] KIND_END   = 3'd3;
   localparam logic [2:0] KIND_ERR   = 3'd4;

   // token attributes
   localparam logic [2:0] ATTR_NONE  = 3'd0;
   localparam logic [2:0] ATTR_LE    = 3'd0;
   localparam logic [2:0] ATTR_NE    = 3'd1;
   localparam logic [2:0] ATTR_LT    = 3'd2;
   localparam logic [2:0] ATTR_EQ    = 3'd3;
   localparam logic [2:0] ATTR_GE    = 3'd4;
   localparam logic [2:0] ATTR_GT    = 3'd5;
   localparam logic [2:0] ATTR_INT   = 3'd0;
   localparam logic [2:0] ATTR_FRAC  = 3'd1;
   localparam logic [2:0] ATTR_EXPO  = 3'd2;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;

   // result queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] attr;
   } token_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] attr;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic [1:0]     cnt;
      token_type      tok0;
      token_type      tok1;
      scan_state_type nxt;
   } step_type;

endpackage
`default_nettype wire

// ===== rtl/rlx_step.sv =====
`default_nettype none
module rlx_step import rlx_pkg::*; (
   input  wire logic [7:0]     ch,
   input  wire scan_state_type state,
   output step_type            res
);

   typedef struct packed {
      logic           has;
      token_type      tok;
      scan_state_type nxt;
   } start_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic start_type from_start(input logic [7:0] c);
      start_type r;
      r.has = 1'b0;
      r.tok = '{kind: KIND_ERR, attr: ATTR_NONE};
      r.nxt = ST_START;
      if (c == CH_NUL) begin
         r.has = 1'b1;
         r.tok = '{kind: KIND_END, attr: ATTR_NONE};
      end else if (c == CH_LT) begin
         r.nxt = ST_LT;
      end else if (c == CH_EQ) begin
         r.has = 1'b1;
         r.tok = '{kind: KIND_RELOP, attr: ATTR_EQ};
      end else if (c == CH_GT) begin
         r.nxt = ST_GT;
      end else if (is_letter(c)) begin
         r.nxt = ST_IDENT;
      end else if (is_digit(c)) begin
         r.nxt = ST_INT;
      end else if (!is_space(c)) begin
         r.has = 1'b1;
      end
      return r;
   endfunction

   start_type fs;
   logic      close;
   token_type close_tok;
   logic      dig;

   always_comb begin
      fs        = from_start(ch);
      dig       = is_digit(ch);
      close     = 1'b0;
      close_tok = '{kind: KIND_ERR, attr: ATTR_NONE};
      res.cnt   = 2'd0;
      res.tok0  = fs.tok;
      res.tok1  = fs.tok;
      res.nxt   = state;
      unique case (state)
         ST_LT: begin
            if (ch == CH_EQ) begin
               res.cnt  = 2'd1;
               res.tok0 = '{kind: KIND_RELOP, attr: ATTR_LE};
               res.nxt  = ST_START;
            end else if (ch == CH_GT) begin
               res.cnt  = 2'd1;
               res.tok0 = '{kind: KIND_RELOP, attr: ATTR_NE};
               res.nxt  = ST_START;
            end else begin
               close     = 1'b1;
               close_tok = '{kind: KIND_RELOP, attr: ATTR_LT};
            end
         end
         ST_GT: begin
            if (ch == CH_EQ) begin
               res.cnt  = 2'd1;
               res.tok0 = '{kind: KIND_RELOP, attr: ATTR_GE};
               res.nxt  = ST_START;
            end else begin
               close     = 1'b1;
               close_tok = '{kind: KIND_RELOP, attr: ATTR_GT};
            end
         end
         ST_IDENT: begin
            if (!(is_letter(ch) || dig)) begin
               close     = 1'b1;
               close_tok = '{kind: KIND_ID, attr: ATTR_NONE};
            end
         end
         ST_INT: begin
            if (ch == CH_DOT) begin
               res.nxt = ST_DOT;
            end else if (ch == CH_E) begin
               res.nxt = ST_EXP;
            end else if (!dig) begin
               close     = 1'b1;
               close_tok = '{kind: KIND_NUM, attr: ATTR_INT};
            end
         end
         ST_DOT: begin
            if (dig) begin
               res.nxt = ST_FRAC;
            end else begin
               res.cnt  = 2'd1;
               res.tok0 = '{kind: KIND_ERR, attr: ATTR_NONE};
               res.nxt  = ST_START;
            end
         end
         ST_FRAC: begin
            if (ch == CH_E) begin
               res.nxt = ST_EXP;
            end else if (!dig) begin
               close     = 1'b1;
               close_tok = '{kind: KIND_NUM, attr: ATTR_FRAC};
            end
         end
         ST_EXP: begin
            if (ch == CH_PLUS || ch == CH_MINUS) begin
               res.nxt = ST_EXPSGN;
            end else if (dig) begin
               res.nxt = ST_EXPDIG;
            end else begin
               res.cnt  = 2'd1;
               res.tok0 = '{kind: KIND_ERR, attr: ATTR_NONE};
               res.nxt  = ST_START;
            end
         end
         ST_EXPSGN: begin
            if (dig) begin
               res.nxt = ST_EXPDIG;
            end else begin
               res.cnt  = 2'd1;
               res.tok0 = '{kind: KIND_ERR, attr: ATTR_NONE};
               res.nxt  = ST_START;
            end
         end
         ST_EXPDIG: begin
            if (!dig) begin
               close     = 1'b1;
               close_tok = '{kind: KIND_NUM, attr: ATTR_EXPO};
            end
         end
         default: begin
            res.cnt  = {1'b0, fs.has};
            res.tok0 = fs.tok;
            res.nxt  = fs.nxt;
         end
      endcase
      // emit the closed token, then rescan this character from start
      if (close) begin
         res.tok0 = close_tok;
         res.tok1 = fs.tok;
         res.cnt  = fs.has ? 2'd2 : 2'd1;
         res.nxt  = fs.nxt;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rlx_outq.sv =====
`default_nettype none
module rlx_outq import rlx_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        push_cnt,
   input  wire entry_type         ent0,
   input  wire entry_type         ent1,
   input  wire logic              pop,
   output entry_type              head,
   output logic [QCNT_W-1:0]      cnt
);

   entry_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [QPTR_W-1:0]   wr_next;

   always_comb begin
      wr_next   = wr_ptr_ff + QPTR_W'(1);
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      cnt_in    = cnt_ff + QCNT_W'(push_cnt) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= ent0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_next] <= ent1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign head = mem_ff[rd_ptr_ff];
   assign cnt  = cnt_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("result queue count beyond depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("pop from empty result queue");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (int'(cnt_ff) + int'(push_cnt)) <= QDEPTH)
      else $error("push into full result queue");

   a_push_cnt: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd3)
      else $error("more than two tokens pushed in one beat");

endmodule
`default_nettype wire

// ===== rtl/relop_id_number_lexer_core.sv =====
`default_nettype none
// Tokens are written into a four-entry result queue when their character is
// accepted; rsp_ presents the queue head. Throughput: one character per cycle
// while req_stall is low; a character that closes one token and is itself a
// one-character token yields two rsp_ beats. req_stall is high while the
// queue holds more than two entries. Reset (synchronous, active high) returns
// the scanner to its start state and empties the result queue.
module relop_id_number_lexer_core import rlx_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_ch,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_kind,
   output logic [2:0]      rsp_attr,
   output logic            rsp_last
);

   scan_state_type    state_ff, state_in;
   step_type          step;
   logic              accept;
   logic [1:0]        push_cnt;
   entry_type         ent0, ent1, head;
   logic [QCNT_W-1:0] q_cnt;
   logic              pop;

   rlx_step u_step (
      .ch    (req_ch),
      .state (state_ff),
      .res   (step)
   );

   always_comb begin
      // hold input while fewer than two slots are free
      req_stall = q_cnt > QCNT_W'(QDEPTH - 2);
      accept    = req_valid && !req_stall;
      push_cnt  = accept ? step.cnt : 2'd0;
      state_in  = accept ? step.nxt : state_ff;
      ent0      = '{kind: step.tok0.kind, attr: step.tok0.attr,
                    last: (step.cnt == 2'd1)};
      ent1      = '{kind: step.tok1.kind, attr: step.tok1.attr, last: 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   rlx_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (push_cnt),
      .ent0     (ent0),
      .ent1     (ent1),
      .pop      (pop),
      .head     (head),
      .cnt      (q_cnt)
   );

   assign rsp_valid = q_cnt != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_kind  = head.kind;
   assign rsp_attr  = head.attr;
   assign rsp_last  = head.last;

endmodule
`default_nettype wire
